[hw/rtl/ihex_pkg.sv]
// Shared types, codes and the character decode for the hex record loader.
`timescale 1ns / 1ps

package ihex_pkg;

    typedef logic [1:0] kind_t;
    typedef logic [7:0] char_t;
    typedef logic [3:0] nibble_t;

    // Result kinds
    localparam kind_t KIND_DATA = 2'd0;
    localparam kind_t KIND_FILL = 2'd1;
    localparam kind_t KIND_EOF  = 2'd2;

    // Characters of interest
    localparam char_t CHAR_COLON      = 8'h3A;
    localparam char_t CHAR_DIGIT_BASE = 8'h30;
    localparam char_t CHAR_ALPHA_BASE = 8'h37;

    // Width of the record byte count
    localparam int COUNT_BITS = 8;

    // Convert one character to a nibble; non-hex characters still give a value
    function automatic nibble_t hex_nibble(input char_t c);
        char_t d;
        d = (c < CHAR_COLON) ? (c - CHAR_DIGIT_BASE) : (c - CHAR_ALPHA_BASE);
        return d[3:0];
    endfunction

endpackage

[hw/rtl/intel_hex_record_loader.sv]
// Top level of the hex record loader: character parser and result register.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------------------------
//  in      | input     | in_valid/in_stall  | in_char
//  out     | output    | out_valid/out_stall| out_kind, out_position, out_byte, fill_length
//
// One character is taken per cycle unless stalled; its result, if any, appears in
// the output register on the next cycle. The parse state is updated in that same cycle.
// in_stall is raised only while a held result is stalled on the output side.
// Reset (rst_n low, asynchronous) returns the parser to colon hunting at position zero.
// After the end-of-file result every further character is taken and dropped.
`timescale 1ns / 1ps

module intel_hex_record_loader #(
    parameter int ADDRESS_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  ihex_pkg::char_t           in_char,
    output logic                      out_valid,
    input  logic                      out_stall,
    output ihex_pkg::kind_t           out_kind,
    output logic [ADDRESS_BITS:0]     out_position,
    output logic [7:0]                out_byte,
    output logic [ADDRESS_BITS-1:0]   fill_length
);
    import ihex_pkg::*;

    localparam int POS_BITS = ADDRESS_BITS + 1;

    // Parser phases
    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_COUNT = 3'd1;
    localparam logic [2:0] PH_ADDR  = 3'd2;
    localparam logic [2:0] PH_TYPE  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;

    logic [2:0]              phase_reg,    phase_next;
    logic [1:0]              digit_reg,    digit_next;
    logic [COUNT_BITS-1:0]   length_reg,   length_next;
    logic [ADDRESS_BITS-1:0] address_reg,  address_next;
    logic [POS_BITS-1:0]     position_reg, position_next;
    nibble_t                 high_reg,     high_next;
    logic                    finished_reg, finished_next;

    logic                    out_valid_reg,    out_valid_next;
    kind_t                   out_kind_reg,     out_kind_next;
    logic [POS_BITS-1:0]     out_position_reg, out_position_next;
    logic [7:0]              out_byte_reg,     out_byte_next;
    logic [ADDRESS_BITS-1:0] fill_length_reg,  fill_length_next;

    logic                    in_accept;
    nibble_t                 nib;
    logic [POS_BITS-1:0]     address_ext;
    logic [POS_BITS-1:0]     record_end;
    logic [POS_BITS-1:0]     fill_diff;
    logic [POS_BITS-1:0]     start_pos;
    logic [POS_BITS-1:0]     pos_inc;

    // Accept whenever the output register is empty or being emptied
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    assign nib         = hex_nibble(in_char);
    assign address_ext = {1'b0, address_reg};
    assign record_end  = address_ext + {{(POS_BITS-COUNT_BITS){1'b0}}, length_reg};
    assign fill_diff   = address_ext - position_reg;
    assign start_pos   = (address_ext > position_reg) ? address_ext : position_reg;
    assign pos_inc     = position_reg + {{(POS_BITS-1){1'b0}}, 1'b1};

    // Advance the parser and build the result for an accepted transaction
    always_comb
    begin
        phase_next        = phase_reg;
        digit_next        = digit_reg;
        length_next       = length_reg;
        address_next      = address_reg;
        position_next     = position_reg;
        high_next         = high_reg;
        finished_next     = finished_reg;

        out_valid_next    = out_valid_reg & out_stall;
        out_kind_next     = out_kind_reg;
        out_position_next = out_position_reg;
        out_byte_next     = out_byte_reg;
        fill_length_next  = fill_length_reg;

        if (in_accept)
        begin
            out_valid_next    = 1'b0;
            out_kind_next     = KIND_DATA;
            out_position_next = position_reg;
            out_byte_next     = '0;
            fill_length_next  = '0;

            if (!finished_reg)
            begin
                case (phase_reg)
                    PH_HUNT:
                    begin
                        if (in_char == CHAR_COLON)
                        begin
                            phase_next = PH_COUNT;
                            digit_next = 2'd0;
                        end
                    end
                    PH_COUNT:
                    begin
                        if (digit_reg == 2'd0)
                        begin
                            high_next  = nib;
                            digit_next = 2'd1;
                        end
                        else
                        begin
                            length_next = {high_reg, nib};
                            digit_next  = 2'd0;
                            if ({high_reg, nib} == '0)
                            begin
                                finished_next  = 1'b1;
                                phase_next     = PH_HUNT;
                                out_valid_next = 1'b1;
                                out_kind_next  = KIND_EOF;
                            end
                            else
                            begin
                                phase_next   = PH_ADDR;
                                address_next = '0;
                            end
                        end
                    end
                    PH_ADDR:
                    begin
                        address_next = {address_reg[ADDRESS_BITS-5:0], nib};
                        if (digit_reg == 2'd3)
                        begin
                            digit_next = 2'd0;
                            phase_next = PH_TYPE;
                        end
                        else
                        begin
                            digit_next = digit_reg + 2'd1;
                        end
                    end
                    PH_TYPE:
                    begin
                        if (digit_reg == 2'd0)
                        begin
                            digit_next = 2'd1;
                        end
                        else
                        begin
                            digit_next = 2'd0;
                            // Zero-fill the gap up to the record address
                            if (address_ext > position_reg)
                            begin
                                out_valid_next   = 1'b1;
                                out_kind_next    = KIND_FILL;
                                fill_length_next = fill_diff[ADDRESS_BITS-1:0];
                            end
                            position_next = start_pos;
                            phase_next    = (record_end > start_pos) ? PH_DATA : PH_HUNT;
                        end
                    end
                    PH_DATA:
                    begin
                        if (digit_reg == 2'd0)
                        begin
                            high_next  = nib;
                            digit_next = 2'd1;
                        end
                        else
                        begin
                            digit_next     = 2'd0;
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_DATA;
                            out_byte_next  = {high_reg, nib};
                            position_next  = pos_inc;
                            if (record_end <= pos_inc)
                            begin
                                phase_next = PH_HUNT;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                        digit_next = 2'd0;
                    end
                endcase
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            digit_reg     <= '0;
            length_reg    <= '0;
            address_reg   <= '0;
            position_reg  <= '0;
            high_reg      <= '0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            digit_reg     <= digit_next;
            length_reg    <= length_next;
            address_reg   <= address_next;
            position_reg  <= position_next;
            high_reg      <= high_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        out_kind_reg     <= out_kind_next;
        out_position_reg <= out_position_next;
        out_byte_reg     <= out_byte_next;
        fill_length_reg  <= fill_length_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_kind     = out_kind_reg;
    assign out_position = out_position_reg;
    assign out_byte     = out_byte_reg;
    assign fill_length  = fill_length_reg;

endmodule

[hw/rtl/ihex_checker.sv]
// Port-level checks for the hex record loader, bound to its top level.
`timescale 1ns / 1ps

module ihex_checker #(
    parameter int ADDRESS_BITS = 16
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input ihex_pkg::kind_t         out_kind,
    input logic [ADDRESS_BITS:0]   out_position,
    input logic [7:0]              out_byte,
    input logic [ADDRESS_BITS-1:0] fill_length
);
    import ihex_pkg::*;

    logic eof_seen_reg;

    // Track an end-of-file transaction leaving the block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eof_seen_reg <= 1'b0;
        end
        else if (out_valid && !out_stall && out_kind == KIND_EOF)
        begin
            eof_seen_reg <= 1'b1;
        end
    end

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_kind)
            && $stable(out_position) && $stable(out_byte) && $stable(fill_length))
        else $error("stalled result changed");

    // Input is only held off by a full, stalled output register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

    // Nothing follows end of file
    assert property (@(posedge clk) disable iff (!rst_n)
        eof_seen_reg |-> !out_valid)
        else $error("result after end of file");

    // Fill runs are never empty, and only fill runs carry a length
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_kind == KIND_FILL) == (fill_length != '0)))
        else $error("fill length inconsistent with kind");

    // Only data bytes carry a byte value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind != KIND_DATA |-> out_byte == '0)
        else $error("byte value on a non-data result");

endmodule

bind intel_hex_record_loader ihex_checker #(.ADDRESS_BITS(ADDRESS_BITS)) u_ihex_checker (.*);

[tb/intel_hex_record_loader_test.sv]
// Self-checking testbench for the Intel-hex record loader, with a character-level predictor.
`timescale 1ns / 1ps

module intel_hex_record_loader_test;

    import ihex_pkg::*;

    localparam int CHAR_TARGET = 900;
    localparam int IDLE_LIMIT  = 2000;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [2:0] {
        SEEK_COLON,
        READ_COUNT,
        READ_ADDRESS,
        READ_TYPE,
        READ_DATA
    } parse_phase_e;

    typedef struct packed {
        kind_t       kind;
        logic [16:0] position;
        logic [7:0]  value;
        logic [15:0] fill;
    } loader_result_t;

    typedef struct packed {
        char_t          ch;
        logic           typed;
        loader_result_t want;
    } char_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    char_t       in_char = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    kind_t       out_kind;
    logic [16:0] out_position;
    logic [7:0]  out_byte;
    logic [15:0] fill_length;

    // Parser state as the predictor sees it
    parse_phase_e phase = SEEK_COLON;
    logic [1:0]   digit_pos = '0;
    nibble_t      upper_nibble = '0;
    logic [7:0]   byte_count = '0;
    logic [15:0]  load_address = '0;
    logic [16:0]  write_position = '0;
    logic         eof_seen = 1'b0;

    loader_result_t pending_results[$];
    int  mismatches = 0;
    int  live_chars = 0;
    int  idle_cycles = 0;
    int  stall_hold = 0;
    logic quiet = 1'b0;

    // Opening characters: noise, a record that fills and writes, an overlapping record that writes nothing
    char_row_t opening_rows [25] = '{
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{":",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"2",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"3",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"0",   1'b1, '{KIND_FILL, 17'd0, 8'h00, 16'd3}},
        '{"F",   1'b0, '0},
        '{"f",   1'b1, '{KIND_DATA, 17'd3, 8'hFF, 16'd0}},
        '{"0",   1'b0, '0},
        '{"0",   1'b1, '{KIND_DATA, 17'd4, 8'h00, 16'd0}},
        '{"C",   1'b0, '0},
        '{":",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"1",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{":",   1'b0, '0},
        '{"0",   1'b0, '0}
    };

    intel_hex_record_loader #(
        .ADDRESS_BITS(16)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_char(in_char),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_kind(out_kind),
        .out_position(out_position),
        .out_byte(out_byte),
        .fill_length(fill_length)
    );

    always #2 clk = ~clk;

    function automatic nibble_t char_nibble(input char_t c);
        char_t d;
        d = c - ((c < CHAR_COLON) ? CHAR_DIGIT_BASE : CHAR_ALPHA_BASE);
        return d[3:0];
    endfunction

    function automatic logic [16:0] load_end();
        return {1'b0, load_address} + {9'd0, byte_count};
    endfunction

    // Advance the parser by one character; return 1 when it yields a result
    function automatic bit decode_char(input char_t c, output loader_result_t res);
        nibble_t n;
        bit hit;
        n = char_nibble(c);
        hit = 1'b0;
        res = '0;
        if (!eof_seen)
        begin
            case (phase)
                SEEK_COLON:
                begin
                    if (c == CHAR_COLON)
                    begin
                        phase = READ_COUNT;
                        digit_pos = '0;
                    end
                end
                READ_COUNT:
                begin
                    if (digit_pos == 2'd0)
                    begin
                        upper_nibble = n;
                        digit_pos = 2'd1;
                    end
                    else
                    begin
                        byte_count = {upper_nibble, n};
                        digit_pos = 2'd0;
                        if (byte_count == 8'd0)
                        begin
                            eof_seen = 1'b1;
                            phase = SEEK_COLON;
                            res.kind = KIND_EOF;
                            res.position = write_position;
                            hit = 1'b1;
                        end
                        else
                        begin
                            phase = READ_ADDRESS;
                            load_address = '0;
                        end
                    end
                end
                READ_ADDRESS:
                begin
                    load_address = {load_address[11:0], n};
                    if (digit_pos == 2'd3)
                    begin
                        digit_pos = 2'd0;
                        phase = READ_TYPE;
                    end
                    else
                    begin
                        digit_pos = digit_pos + 2'd1;
                    end
                end
                READ_TYPE:
                begin
                    if (digit_pos == 2'd0)
                    begin
                        digit_pos = 2'd1;
                    end
                    else
                    begin
                        digit_pos = 2'd0;
                        if ({1'b0, load_address} > write_position)
                        begin
                            res.kind = KIND_FILL;
                            res.position = write_position;
                            res.fill = load_address - write_position[15:0];
                            write_position = {1'b0, load_address};
                            hit = 1'b1;
                        end
                        phase = (load_end() > write_position) ? READ_DATA : SEEK_COLON;
                    end
                end
                READ_DATA:
                begin
                    if (digit_pos == 2'd0)
                    begin
                        upper_nibble = n;
                        digit_pos = 2'd1;
                    end
                    else
                    begin
                        digit_pos = 2'd0;
                        res.kind = KIND_DATA;
                        res.position = write_position;
                        res.value = {upper_nibble, n};
                        hit = 1'b1;
                        write_position = write_position + 17'd1;
                        if (load_end() <= write_position)
                            phase = SEEK_COLON;
                    end
                end
                default:
                begin
                    phase = SEEK_COLON;
                    digit_pos = '0;
                end
            endcase
        end
        return hit;
    endfunction

    // Idle length: mostly none or short, a few long
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    // Pick one of several spellings that decode to the given nibble
    function automatic char_t hex_char(input nibble_t n);
        case ($urandom_range(0, 3))
            1:       return (n < 4'd10) ? CHAR_DIGIT_BASE + n : 8'h61 + n - 8'd10;
            2:       return CHAR_ALPHA_BASE + 8'(8'h10 * $urandom_range(1, 11)) + n;
            default: return (n < 4'd10) ? CHAR_DIGIT_BASE + n : 8'h41 + n - 8'd10;
        endcase
    endfunction

    // Send one character and record what it should produce
    task automatic send_char(input char_t c, input bit end_ok, input bit typed,
                             input loader_result_t want);
        int gap;
        char_t ch;
        loader_result_t got;
        bit hit;
        ch = c;
        // keep a stray zero byte count from ending the file early
        if (!end_ok && !eof_seen && phase == READ_COUNT && digit_pos == 2'd1
            && upper_nibble == 4'd0 && char_nibble(ch) == 4'd0)
            ch = ch ^ 8'h01;
        if (!eof_seen && (phase != SEEK_COLON || ch == CHAR_COLON))
            live_chars++;
        gap = quiet ? 0 : idle_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_char <= ch;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        hit = decode_char(ch, got);
        if (typed)
            pending_results.push_back(want);
        else if (hit)
            pending_results.push_back(got);
    endtask

    task automatic send_plain(input char_t c);
        send_char(c, 1'b0, 1'b0, '0);
    endtask

    // Send a record with random type, data and checksum digits; some data characters are random bytes
    task automatic send_record(input logic [7:0] len, input logic [15:0] addr);
        send_plain(CHAR_COLON);
        send_plain(hex_char(len[7:4]));
        send_plain(hex_char(len[3:0]));
        for (int i = 3; i >= 0; i--)
            send_plain(hex_char(addr[4*i +: 4]));
        repeat (2) send_plain(hex_char(4'($urandom_range(0, 15))));
        for (int i = 0; i < 2 * len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_plain(8'($urandom_range(0, 255)));
            else
                send_plain(hex_char(4'($urandom_range(0, 15))));
        end
        repeat (2) send_plain(hex_char(4'($urandom_range(0, 15))));
    endtask

    // Check each result transaction and drive the output stall pattern
    always @(posedge clk)
    begin
        loader_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: kind %0d pos %h byte %h fill %h",
                             out_kind, out_position, out_byte, fill_length);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_kind !== want.kind || out_position !== want.position
                    || out_byte !== want.value || fill_length !== want.fill)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch: expected kind %0d pos %h byte %h fill %h, ",
                                  "got kind %0d pos %h byte %h fill %h"},
                                 want.kind, want.position, want.value, want.fill,
                                 out_kind, out_position, out_byte, fill_length);
                end
            end
        end
        // hold the current stall level, then alternate between stall and release
        if (quiet)
        begin
            out_stall <= 1'b0;
            stall_hold = 0;
        end
        else if (stall_hold > 0)
        begin
            stall_hold--;
        end
        else if (out_stall)
        begin
            out_stall <= 1'b0;
            stall_hold = $urandom_range(0, 4);
        end
        else
        begin
            stall_hold = idle_length();
            if (stall_hold > 0)
            begin
                out_stall <= 1'b1;
                stall_hold--;
            end
            else
            begin
                stall_hold = $urandom_range(0, 4);
            end
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        int pick;
        int k;
        logic [7:0] len;
        logic [15:0] addr;
        logic [16:0] pos;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening
        foreach (opening_rows[i])
            send_char(opening_rows[i].ch, 1'b0, opening_rows[i].typed, opening_rows[i].want);

        // Random records, mostly near the write position, with noise and broken records
        while (live_chars < CHAR_TARGET)
        begin
            quiet <= ($urandom_range(0, 9) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                len = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(17, 64))
                                                   : 8'($urandom_range(1, 16));
                pos = write_position;
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    addr = pos[15:0];
                end
                else if (pick < 75)
                begin
                    addr = pos[15:0] + 16'($urandom_range(1, 40));
                end
                else if (pick < 92)
                begin
                    k = $urandom_range(1, 24);
                    addr = (pos > k) ? 16'(pos - k) : 16'd0;
                end
                else
                begin
                    addr = 16'($urandom_range(0, pos));
                end
                send_record(len, addr);
            end
            else if (pick < 88)
            begin
                repeat ($urandom_range(1, 6)) send_plain(8'($urandom_range(0, 255)));
            end
            else
            begin
                send_plain(CHAR_COLON);
                repeat ($urandom_range(1, 8)) send_plain(hex_char(4'($urandom_range(0, 15))));
            end
        end

        // Finish any broken record so the closing one starts while hunting for a colon
        while (phase != SEEK_COLON)
            send_plain("0");

        // Close with the widest record at the top address, end of file, then ignored input
        quiet <= 1'b0;
        send_record(8'hFF, 16'hFFFF);
        send_plain(CHAR_COLON);
        repeat (2) send_char("0", 1'b1, 1'b0, '0);
        repeat (4) send_plain("0");
        send_plain("0");
        send_plain("1");
        repeat (2) send_plain("F");
        repeat (24) send_char(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
